>>> design/ecal_pkg.sv
package ecal_pkg;

  // Register stages from the input register to the result register
  localparam int unsigned NumStages = 11;

  // Seconds per day is 675 << 7: drop 7 bits, then divide by 675
  localparam int unsigned DayShift = 7;
  localparam logic [9:0]  DayDiv   = 10'd675;
  // 675 * 6362915, large enough to lift any shifted input above zero
  localparam logic [33:0] SecsBias = 34'd4294967625;
  // floor(2^34 / 675)
  localparam logic [24:0] DayRecip = 25'd25451658;
  localparam int unsigned DayRecipShift = 34;

  // Biased day count: q + 54336 equals days + 719468 + 39 eras
  localparam logic [25:0] EraBias  = 26'd54336;
  localparam logic [17:0] EraDays  = 18'd146097;
  // floor(2^26 / 146097)
  localparam logic [8:0]  EraRecip = 9'd459;
  localparam int unsigned EraRecipShift = 26;

  localparam logic [11:0] SecsPerHour  = 12'd3600;
  localparam logic [5:0]  HourRecip    = 6'd36;     // floor(2^17 / 3600)
  localparam int unsigned HourRecipShift = 17;

  localparam logic [5:0]  SecsPerMin   = 6'd60;
  localparam logic [6:0]  MinRecip     = 7'd68;     // floor(2^12 / 60)
  localparam int unsigned MinRecipShift = 12;

  localparam logic [10:0] DaysPer4Yr   = 11'd1460;
  localparam logic [7:0]  Recip4Yr     = 8'd179;    // floor(2^18 / 1460)
  localparam logic [17:0] DaysPerCent  = 18'd36524;
  localparam logic [17:0] EraLastDay   = 18'd146096;

  localparam logic [8:0]  DaysPerYear  = 9'd365;
  localparam logic [9:0]  YearRecip    = 10'd718;   // floor(2^18 / 365)

  localparam logic [2:0]  DaysPerWeek  = 3'd7;
  localparam logic [15:0] WeekRecip    = 16'd37449; // floor(2^18 / 7)
  localparam logic [1:0]  WeekOffset   = 2'd3;      // era starts on a Wednesday

  localparam int unsigned DateRecipShift = 18;

  // 400 * 39 eras of bias plus the 1900 origin
  localparam logic [19:0] YearBias     = 20'd17500;
  localparam logic [8:0]  YearsPerEra  = 9'd400;

  // First day of each month in a year that begins on March 1
  function automatic logic [8:0] month_start(logic [3:0] mp);
    logic [8:0] start;
    begin
      unique case (mp)
        4'd0:    start = 9'd0;
        4'd1:    start = 9'd31;
        4'd2:    start = 9'd61;
        4'd3:    start = 9'd92;
        4'd4:    start = 9'd122;
        4'd5:    start = 9'd153;
        4'd6:    start = 9'd184;
        4'd7:    start = 9'd214;
        4'd8:    start = 9'd245;
        4'd9:    start = 9'd275;
        4'd10:   start = 9'd306;
        4'd11:   start = 9'd337;
        default: start = 9'd0;
      endcase
      return start;
    end
  endfunction

endpackage

>>> design/ecal_flow.sv
module ecal_flow #(
  parameter int unsigned NumStages = ecal_pkg::NumStages
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [NumStages-1:0] stage_en_o
);

  logic [NumStages-1:0] valid_q, valid_d;
  logic [NumStages-1:0] empty;

  assign empty = ~valid_q;

  // A stage may load when the output drains or any stage at or after it is empty
  always_comb begin
    for (int unsigned k = 0; k < NumStages; k++) begin
      stage_en_o[k] = out_ready_i || ((empty >> k) != '0);
    end
  end

  // Advance the valid bits along with the data
  always_comb begin
    valid_d = valid_q;
    if (stage_en_o[0]) begin
      valid_d[0] = in_valid_i;
    end
    for (int unsigned k = 1; k < NumStages; k++) begin
      if (stage_en_o[k]) begin
        valid_d[k] = valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o  = stage_en_o[0];
  assign out_valid_o = valid_q[NumStages-1];

endmodule

>>> design/epoch_seconds_to_calendar_unit.sv
// Converts a signed 40-bit count of seconds since 1970-01-01 00:00:00 UTC into the
// proleptic Gregorian date and time of day (year minus 1900, month from 0, day of
// month, hour, minute, second, weekday with Sunday as 0, day of year from 0).
// Negative inputs floor to the earlier day. The block is an 11-stage pipeline
// that takes one item every cycle while in_ready_o is high. Its depth comes from
// the constant divisions (by 86400, 146097, 3600, 60, 1460, 365 and 7): each is a
// reciprocal multiply that is registered, then a back-multiply with a single
// compare-and-subtract correction. Stalls on the output fill bubbles in the
// pipeline before the input side sees ready drop.
module epoch_seconds_to_calendar_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [39:0] epoch_seconds_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] year_since_1900_o,
  output logic [3:0]         month_index_o,
  output logic [4:0]         day_of_month_o,
  output logic [4:0]         hour_of_day_o,
  output logic [5:0]         minute_of_hour_o,
  output logic [5:0]         second_of_minute_o,
  output logic [2:0]         weekday_o,
  output logic [8:0]         day_of_year_o
);

  localparam int unsigned NumStages = ecal_pkg::NumStages;

  logic [NumStages-1:0] stage_en;

  ecal_flow #(
    .NumStages(NumStages)
  ) u_flow (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .stage_en_o (stage_en)
  );

  // ---------------------------------------------------------------- stage 0
  logic signed [39:0] secs_q;

  always_ff @(posedge clk_i) begin
    if (stage_en[0]) begin
      secs_q <= epoch_seconds_i;
    end
  end

  // ---------------------------------------------------------------- stage 1
  // Shift off 128 s, lift above zero, estimate the quotient by 675
  logic [32:0] secs_hi;
  logic [33:0] secs_lift;
  logic [58:0] day_prod;
  logic [33:0] lift1_q;
  logic [24:0] dayest1_q;
  logic [6:0]  secs_lo1_q;

  assign secs_hi   = secs_q[39:ecal_pkg::DayShift];
  assign secs_lift = {secs_hi[32], secs_hi} + ecal_pkg::SecsBias;
  assign day_prod  = 59'(secs_lift) * 59'(ecal_pkg::DayRecip);

  always_ff @(posedge clk_i) begin
    if (stage_en[1]) begin
      lift1_q    <= secs_lift;
      dayest1_q  <= day_prod[58:ecal_pkg::DayRecipShift];
      secs_lo1_q <= secs_q[6:0];
    end
  end

  // ---------------------------------------------------------------- stage 2
  // Correct the day quotient, build the second of the day and the biased day
  logic [33:0] day_diff;
  logic [10:0] day_rem;
  logic        day_fix;
  logic [24:0] day_q;
  logic [9:0]  day_rem_c;
  logic [25:0] zb2_q;
  logic [16:0] sod2_q;

  assign day_diff  = lift1_q - 34'(35'(dayest1_q) * 35'(ecal_pkg::DayDiv));
  assign day_rem   = day_diff[10:0];
  assign day_fix   = day_rem >= 11'(ecal_pkg::DayDiv);
  assign day_q     = dayest1_q + 25'(day_fix);
  assign day_rem_c = day_fix ? 10'(day_rem - 11'(ecal_pkg::DayDiv)) : day_rem[9:0];

  always_ff @(posedge clk_i) begin
    if (stage_en[2]) begin
      zb2_q  <= 26'(day_q) + ecal_pkg::EraBias;
      sod2_q <= {day_rem_c, secs_lo1_q};
    end
  end

  // ---------------------------------------------------------------- stage 3
  // Estimate the era and the hour
  logic [34:0] era_prod;
  logic [22:0] hour_prod;
  logic [25:0] zb3_q;
  logic [8:0]  eraest3_q;
  logic [16:0] sod3_q;
  logic [5:0]  hourest3_q;

  assign era_prod  = 35'(zb2_q) * 35'(ecal_pkg::EraRecip);
  assign hour_prod = 23'(sod2_q) * 23'(ecal_pkg::HourRecip);

  always_ff @(posedge clk_i) begin
    if (stage_en[3]) begin
      zb3_q      <= zb2_q;
      eraest3_q  <= era_prod[34:ecal_pkg::EraRecipShift];
      sod3_q     <= sod2_q;
      hourest3_q <= hour_prod[22:ecal_pkg::HourRecipShift];
    end
  end

  // ---------------------------------------------------------------- stage 4
  // Correct era and hour, leaving day of era and second of the hour
  logic [25:0] era_diff;
  logic [18:0] era_rem;
  logic        era_fix;
  logic [16:0] hour_diff;
  logic [12:0] hour_rem;
  logic        hour_fix;
  logic [17:0] doe4_q;
  logic [8:0]  era4_q;
  logic [4:0]  hour4_q;
  logic [11:0] rs4_q;

  assign era_diff  = zb3_q - 26'(26'(eraest3_q) * 26'(ecal_pkg::EraDays));
  assign era_rem   = era_diff[18:0];
  assign era_fix   = era_rem >= 19'(ecal_pkg::EraDays);
  assign hour_diff = sod3_q - 17'(17'(hourest3_q) * 17'(ecal_pkg::SecsPerHour));
  assign hour_rem  = hour_diff[12:0];
  assign hour_fix  = hour_rem >= 13'(ecal_pkg::SecsPerHour);

  always_ff @(posedge clk_i) begin
    if (stage_en[4]) begin
      doe4_q  <= era_fix ? 18'(era_rem - 19'(ecal_pkg::EraDays)) : era_rem[17:0];
      era4_q  <= eraest3_q + 9'(era_fix);
      hour4_q <= 5'(hourest3_q + 6'(hour_fix));
      rs4_q   <= hour_fix ? 12'(hour_rem - 13'(ecal_pkg::SecsPerHour)) : hour_rem[11:0];
    end
  end

  // ---------------------------------------------------------------- stage 5
  // Estimate 4-year cycles, minutes and weekday; count centuries by compare
  logic [25:0] cyc_prod;
  logic [33:0] week_prod;
  logic [18:0] min_prod;
  logic [17:0] week_arg;
  logic [2:0]  cent_cnt;
  logic [17:0] doe5_q;
  logic [7:0]  cycest5_q;
  logic [2:0]  cent5_q;
  logic        last5_q;
  logic [17:0] warg5_q;
  logic [15:0] wkest5_q;
  logic [8:0]  era5_q;
  logic [4:0]  hour5_q;
  logic [11:0] rs5_q;
  logic [6:0]  minest5_q;

  assign cyc_prod  = 26'(doe4_q) * 26'(ecal_pkg::Recip4Yr);
  assign week_arg  = doe4_q + 18'(ecal_pkg::WeekOffset);
  assign week_prod = 34'(week_arg) * 34'(ecal_pkg::WeekRecip);
  assign min_prod  = 19'(rs4_q) * 19'(ecal_pkg::MinRecip);

  always_comb begin
    cent_cnt = '0;
    for (int unsigned k = 1; k <= 4; k++) begin
      cent_cnt = cent_cnt + 3'(doe4_q >= 18'(k * ecal_pkg::DaysPerCent));
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_en[5]) begin
      doe5_q    <= doe4_q;
      cycest5_q <= cyc_prod[25:ecal_pkg::DateRecipShift];
      cent5_q   <= cent_cnt;
      last5_q   <= doe4_q == ecal_pkg::EraLastDay;
      warg5_q   <= week_arg;
      wkest5_q  <= week_prod[33:ecal_pkg::DateRecipShift];
      era5_q    <= era4_q;
      hour5_q   <= hour4_q;
      rs5_q     <= rs4_q;
      minest5_q <= min_prod[18:ecal_pkg::MinRecipShift];
    end
  end

  // ---------------------------------------------------------------- stage 6
  // Correct cycles, weekday and minute; form the day count for the year divide
  logic [17:0] cyc_diff;
  logic [11:0] cyc_rem;
  logic [7:0]  cyc_cnt;
  logic [17:0] week_diff;
  logic [3:0]  week_rem;
  logic [11:0] min_diff;
  logic [6:0]  min_rem;
  logic        min_fix;
  logic [17:0] t6_q;
  logic [17:0] doe6_q;
  logic [8:0]  era6_q;
  logic [4:0]  hour6_q;
  logic [5:0]  min6_q;
  logic [5:0]  sec6_q;
  logic [2:0]  wday6_q;

  assign cyc_diff  = doe5_q - 18'(18'(cycest5_q) * 18'(ecal_pkg::DaysPer4Yr));
  assign cyc_rem   = cyc_diff[11:0];
  assign cyc_cnt   = cycest5_q + 8'(cyc_rem >= 12'(ecal_pkg::DaysPer4Yr));
  assign week_diff = warg5_q - 18'(18'(wkest5_q) * 18'(ecal_pkg::DaysPerWeek));
  assign week_rem  = week_diff[3:0];
  assign min_diff  = rs5_q - 12'(12'(minest5_q) * 12'(ecal_pkg::SecsPerMin));
  assign min_rem   = min_diff[6:0];
  assign min_fix   = min_rem >= 7'(ecal_pkg::SecsPerMin);

  always_ff @(posedge clk_i) begin
    if (stage_en[6]) begin
      t6_q    <= doe5_q - 18'(cyc_cnt) + 18'(cent5_q) - 18'(last5_q);
      doe6_q  <= doe5_q;
      era6_q  <= era5_q;
      hour6_q <= hour5_q;
      min6_q  <= 6'(minest5_q + 7'(min_fix));
      sec6_q  <= min_fix ? 6'(min_rem - 7'(ecal_pkg::SecsPerMin)) : min_rem[5:0];
      wday6_q <= (week_rem >= 4'(ecal_pkg::DaysPerWeek))
                 ? 3'(week_rem - 4'(ecal_pkg::DaysPerWeek)) : week_rem[2:0];
    end
  end

  // ---------------------------------------------------------------- stage 7
  // Estimate the year of the era
  logic [27:0] year_prod;
  logic [17:0] t7_q;
  logic [9:0]  yest7_q;
  logic [17:0] doe7_q;
  logic [8:0]  era7_q;
  logic [4:0]  hour7_q;
  logic [5:0]  min7_q;
  logic [5:0]  sec7_q;
  logic [2:0]  wday7_q;

  assign year_prod = 28'(t6_q) * 28'(ecal_pkg::YearRecip);

  always_ff @(posedge clk_i) begin
    if (stage_en[7]) begin
      t7_q    <= t6_q;
      yest7_q <= year_prod[27:ecal_pkg::DateRecipShift];
      doe7_q  <= doe6_q;
      era7_q  <= era6_q;
      hour7_q <= hour6_q;
      min7_q  <= min6_q;
      sec7_q  <= sec6_q;
      wday7_q <= wday6_q;
    end
  end

  // ---------------------------------------------------------------- stage 8
  // Correct the year of the era
  logic [17:0] year_diff;
  logic [9:0]  year_rem;
  logic [9:0]  yoe_c;
  logic [8:0]  yoe8_q;
  logic [17:0] doe8_q;
  logic [8:0]  era8_q;
  logic [4:0]  hour8_q;
  logic [5:0]  min8_q;
  logic [5:0]  sec8_q;
  logic [2:0]  wday8_q;

  assign year_diff = t7_q - 18'(18'(yest7_q) * 18'(ecal_pkg::DaysPerYear));
  assign year_rem  = year_diff[9:0];
  assign yoe_c     = yest7_q + 10'(year_rem >= 10'(ecal_pkg::DaysPerYear));

  always_ff @(posedge clk_i) begin
    if (stage_en[8]) begin
      yoe8_q  <= yoe_c[8:0];
      doe8_q  <= doe7_q;
      era8_q  <= era7_q;
      hour8_q <= hour7_q;
      min8_q  <= min7_q;
      sec8_q  <= sec7_q;
      wday8_q <= wday7_q;
    end
  end

  // ---------------------------------------------------------------- stage 9
  // Day of the March-based year
  logic [1:0]  yoe_cent;
  logic [17:0] year_base;
  logic [17:0] doy_w;
  logic [8:0]  doy9_q;
  logic [8:0]  yoe9_q;
  logic [8:0]  era9_q;
  logic [4:0]  hour9_q;
  logic [5:0]  min9_q;
  logic [5:0]  sec9_q;
  logic [2:0]  wday9_q;

  assign yoe_cent  = 2'(yoe8_q >= 9'd100) + 2'(yoe8_q >= 9'd200) + 2'(yoe8_q >= 9'd300);
  assign year_base = 18'(yoe8_q) * 18'(ecal_pkg::DaysPerYear)
                     + 18'(yoe8_q[8:2]) - 18'(yoe_cent);
  assign doy_w     = doe8_q - year_base;

  always_ff @(posedge clk_i) begin
    if (stage_en[9]) begin
      doy9_q  <= doy_w[8:0];
      yoe9_q  <= yoe8_q;
      era9_q  <= era8_q;
      hour9_q <= hour8_q;
      min9_q  <= min8_q;
      sec9_q  <= sec8_q;
      wday9_q <= wday8_q;
    end
  end

  // --------------------------------------------------------------- stage 10
  // Month, day, leap year, civil year and result register
  logic [3:0]  mp;
  logic        jan_feb;
  logic [9:0]  civ_yoe;
  logic        leap;
  logic [19:0] year_w;
  logic [8:0]  yday;
  logic [4:0]  mday;
  logic [3:0]  mon_idx;
  logic signed [15:0] year_q;
  logic [3:0]  month_q;
  logic [4:0]  mday_q;
  logic [4:0]  hour_q;
  logic [5:0]  min_q;
  logic [5:0]  sec_q;
  logic [2:0]  wday_q;
  logic [8:0]  yday_q;

  // Pick the last month whose first day is not past the day of year
  always_comb begin
    mp = '0;
    for (int unsigned k = 1; k < 12; k++) begin
      if (doy9_q >= ecal_pkg::month_start(4'(k))) begin
        mp = 4'(k);
      end
    end
  end

  assign jan_feb = mp >= 4'd10;
  assign civ_yoe = 10'(yoe9_q) + 10'(jan_feb);
  assign leap    = (civ_yoe[1:0] == 2'd0) && (civ_yoe != 10'd100)
                   && (civ_yoe != 10'd200) && (civ_yoe != 10'd300);
  assign year_w  = 20'(civ_yoe) + 20'(era9_q) * 20'(ecal_pkg::YearsPerEra)
                   - ecal_pkg::YearBias;
  assign mday    = 5'(doy9_q - ecal_pkg::month_start(mp) + 9'd1);
  assign mon_idx = jan_feb ? mp - 4'd10 : mp + 4'd2;
  assign yday    = jan_feb ? doy9_q - 9'd306 : doy9_q + 9'd59 + 9'(leap);

  always_ff @(posedge clk_i) begin
    if (stage_en[10]) begin
      year_q  <= signed'(year_w[15:0]);
      month_q <= mon_idx;
      mday_q  <= mday;
      hour_q  <= hour9_q;
      min_q   <= min9_q;
      sec_q   <= sec9_q;
      wday_q  <= wday9_q;
      yday_q  <= yday;
    end
  end

  assign year_since_1900_o  = year_q;
  assign month_index_o      = month_q;
  assign day_of_month_o     = mday_q;
  assign hour_of_day_o      = hour_q;
  assign minute_of_hour_o   = min_q;
  assign second_of_minute_o = sec_q;
  assign weekday_o          = wday_q;
  assign day_of_year_o      = yday_q;

  // ------------------------------------------------------------- assertions
  // Input stalls only when every stage, including the result register, is full
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with a bubble in the pipeline");

  // Time-of-day corrections leave fields in range
  a_tod_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (hour_of_day_o < 5'd24) && (minute_of_hour_o < 6'd60)
                    && (second_of_minute_o < 6'd60))
    else $error("time of day out of range");

  // Date fields in range
  a_date_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (month_index_o < 4'd12) && (day_of_month_o != 5'd0)
                    && (weekday_o < 3'd7) && (day_of_year_o < 9'd366))
    else $error("date field out of range");

  // In January the day of year follows the day of month
  a_jan_yday: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (month_index_o == 4'd0) |->
      day_of_year_o == 9'(day_of_month_o) - 9'd1)
    else $error("January day of year mismatch");

endmodule
